[rtl/mbrr_pkg.sv]
// Shared constants, types and the CRC-16 byte step for the Modbus RTU register read unit.
package mbrr_pkg;

   // Stream widths
   localparam int REQ_DATA_W  = 32;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 1;
   localparam int TIMEOUT_W   = 10;

   // Request word opcodes (tuser)
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_RX_BYTE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   // Response kinds (tuser)
   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Completion status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CRC     = 2'd1;
   localparam logic [1:0] ST_HEADER  = 2'd2;
   localparam logic [1:0] ST_TIMEOUT = 2'd3;

   // Protocol constants
   localparam logic [15:0]          CRC_INIT       = 16'hFFFF;
   localparam logic [15:0]          CRC_POLY       = 16'hA001;
   localparam logic [7:0]           FUNC_READ_HOLD = 8'h03;
   localparam logic [7:0]           BYTE_COUNT_ONE = 8'h02;
   localparam logic [7:0]           QUANTITY_ONE   = 8'h01;
   localparam logic [7:0]           QUANTITY_HI    = 8'h00;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 10'd200;

   // Reply byte positions
   localparam logic [2:0] RX_ADDR   = 3'd0;
   localparam logic [2:0] RX_FUNC   = 3'd1;
   localparam logic [2:0] RX_COUNT  = 3'd2;
   localparam logic [2:0] RX_DATA_H = 3'd3;
   localparam logic [2:0] RX_DATA_L = 3'd4;
   localparam logic [2:0] RX_CRC_L  = 3'd5;
   localparam logic [2:0] RX_CRC_H  = 3'd6;
   localparam logic [2:0] RX_DONE   = 3'd7;

   // Command from reply logic to the response emitter
   typedef struct packed {
      logic        load_frame;
      logic        load_report;
      logic [7:0]  slave_addr;
      logic [15:0] reg_addr;
      logic [1:0]  status;
      logic [15:0] value;
   } mbrr_load_type;

   // One byte through the reflected CRC-16
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/mbrr_emit.sv]
// Response emitter: streams the request frame bytes with running CRC, or one report word.
module mbrr_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  mbrr_pkg::mbrr_load_type           load,
   output logic                              free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mbrr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic [mbrr_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import mbrr_pkg::*;

   // Frame byte positions
   localparam logic [2:0] TX_ADDR  = 3'd0;
   localparam logic [2:0] TX_FUNC  = 3'd1;
   localparam logic [2:0] TX_REG_H = 3'd2;
   localparam logic [2:0] TX_REG_L = 3'd3;
   localparam logic [2:0] TX_QTY_H = 3'd4;
   localparam logic [2:0] TX_QTY_L = 3'd5;
   localparam logic [2:0] TX_CRC_L = 3'd6;
   localparam logic [2:0] TX_CRC_H = 3'd7;

   logic        busy_ff, busy_in;
   logic        report_ff, report_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  slave_ff, slave_in;
   logic [15:0] reg_ff, reg_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] value_ff, value_in;

   logic       fire;
   logic       at_end;
   logic [7:0] tx_byte;

   always_comb begin
      unique case (idx_ff)
         TX_ADDR:  tx_byte = slave_ff;
         TX_FUNC:  tx_byte = FUNC_READ_HOLD;
         TX_REG_H: tx_byte = reg_ff[15:8];
         TX_REG_L: tx_byte = reg_ff[7:0];
         TX_QTY_H: tx_byte = QUANTITY_HI;
         TX_QTY_L: tx_byte = QUANTITY_ONE;
         TX_CRC_L: tx_byte = crc_ff[7:0];
         TX_CRC_H: tx_byte = crc_ff[15:8];
         default:  tx_byte = 8'h00;
      endcase
   end

   assign fire   = busy_ff && rsp_tready;
   assign at_end = report_ff || (idx_ff == TX_CRC_H);
   assign free   = !busy_ff || (fire && at_end);

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = !report_ff && (idx_ff == TX_CRC_H);
   assign rsp_tuser  = report_ff ? KIND_REPORT : KIND_TX;
   // tdata: tx_byte [7:0], status [9:8], value [25:10], zero [31:26]
   assign rsp_tdata  = report_ff
      ? {6'd0, value_ff, status_ff, 8'h00}
      : {6'd0, 16'h0000, ST_OK, tx_byte};

   always_comb begin
      busy_in   = busy_ff;
      report_in = report_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      slave_in  = slave_ff;
      reg_in    = reg_ff;
      status_in = status_ff;
      value_in  = value_ff;

      if (fire) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
            // CRC covers the six header bytes only
            if (idx_ff <= TX_QTY_L) begin
               crc_in = crc_feed(crc_ff, tx_byte);
            end
         end
      end

      if (load.load_frame) begin
         busy_in   = 1'b1;
         report_in = 1'b0;
         idx_in    = TX_ADDR;
         crc_in    = CRC_INIT;
         slave_in  = load.slave_addr;
         reg_in    = load.reg_addr;
      end else if (load.load_report) begin
         busy_in   = 1'b1;
         report_in = 1'b1;
         idx_in    = TX_ADDR;
         status_in = load.status;
         value_in  = load.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         report_ff <= 1'b0;
         idx_ff    <= TX_ADDR;
      end else begin
         busy_ff   <= busy_in;
         report_ff <= report_in;
         idx_ff    <= idx_in;
      end
      crc_ff    <= crc_in;
      slave_ff  <= slave_in;
      reg_ff    <= reg_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

endmodule

[rtl/modbus_rtu_single_register_read_unit.sv]
// Top level of the Modbus RTU single holding-register read unit (function 3 master).
//
//   channel  dir  handshake               payload
//   req_     in   tvalid/tready           tuser = op, tdata = slave/reg/rx byte
//   rsp_     out  tvalid/tready, tlast    tuser = kind, tdata = tx byte/status/value
//   csr_     in   csr_wen                 csr_wdata = reply timeout in ms
//
// A request word is registered in the input register, then processed from there: one
// word per cycle while the response side keeps up. A start request yields eight response
// words, one per cycle from the emitter while rsp_tready is high; the frame CRC is
// accumulated byte by byte as the frame is sent.
// Words that produce no response (most received bytes, ticks) never wait on the emitter.
// Synchronous reset returns the reply tracker to idle and the timeout to 200 ms.
module modbus_rtu_single_register_read_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [7:0] slave_addr, [23:8] reg_addr, [31:24] rx_byte
   input  logic [mbrr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] op
   input  logic [mbrr_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] tx_byte, [9:8] status, [25:10] value, [31:26] zero
   output logic [mbrr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   // [0] kind
   output logic [mbrr_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic                             csr_wen,
   input  logic [mbrr_pkg::TIMEOUT_W-1:0]   csr_wdata
);
   import mbrr_pkg::*;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_op_ff;
   logic [7:0]  in_slave_ff;
   logic [15:0] in_reg_ff;
   logic [7:0]  in_rx_ff;

   // reply tracker
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [7:0]           expected_ff, expected_in;
   logic                 awaiting_ff, awaiting_in;
   logic [2:0]           rx_cnt_ff, rx_cnt_in;
   logic [15:0]          rx_crc_ff, rx_crc_in;
   logic                 hdr_good_ff, hdr_good_in;
   logic [15:0]          data_ff, data_in;
   logic [7:0]           crc_lo_ff, crc_lo_in;
   logic [TIMEOUT_W-1:0] elapsed_ff, elapsed_in;

   logic                 req_fire;
   logic                 go;
   logic                 emit_free;
   logic                 want_frame, want_report;
   logic [1:0]           rep_status;
   logic [15:0]          rep_value;
   logic [15:0]          rx_crc_next;
   logic [TIMEOUT_W-1:0] elapsed_sat;
   mbrr_load_type        ld;

   assign req_fire    = req_tvalid && req_tready;
   assign rx_crc_next = crc_feed(rx_crc_ff, in_rx_ff);
   assign elapsed_sat = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   // which words produce a response, and what
   always_comb begin
      want_frame  = 1'b0;
      want_report = 1'b0;
      rep_status  = ST_OK;
      rep_value   = 16'h0000;
      case (in_op_ff)
         OP_START: want_frame = 1'b1;
         OP_RX_BYTE: begin
            if (awaiting_ff && (rx_cnt_ff == RX_CRC_H)) begin
               want_report = 1'b1;
               // CRC mismatch wins over a bad header
               if ({in_rx_ff, crc_lo_ff} != rx_crc_ff) begin
                  rep_status = ST_CRC;
               end else if (!hdr_good_ff) begin
                  rep_status = ST_HEADER;
               end else begin
                  rep_value = data_ff;
               end
            end
         end
         OP_TICK: begin
            if (awaiting_ff && (elapsed_sat >= timeout_ff)) begin
               want_report = 1'b1;
               rep_status  = ST_TIMEOUT;
            end
         end
         default: ;
      endcase
   end

   // words without a response never wait on the emitter
   assign go          = in_valid_ff && (!(want_frame || want_report) || emit_free);
   assign req_tready  = !in_valid_ff || go;
   assign in_valid_in = req_fire || (in_valid_ff && !go);

   always_comb begin
      ld.load_frame  = go && want_frame;
      ld.load_report = go && want_report;
      ld.slave_addr  = in_slave_ff;
      ld.reg_addr    = in_reg_ff;
      ld.status      = rep_status;
      ld.value       = rep_value;
   end

   // reply tracker update
   always_comb begin
      timeout_in  = csr_wen ? csr_wdata : timeout_ff;
      expected_in = expected_ff;
      awaiting_in = awaiting_ff;
      rx_cnt_in   = rx_cnt_ff;
      rx_crc_in   = rx_crc_ff;
      hdr_good_in = hdr_good_ff;
      data_in     = data_ff;
      crc_lo_in   = crc_lo_ff;
      elapsed_in  = elapsed_ff;

      if (go) begin
         case (in_op_ff)
            OP_START: begin
               // a new request drops any reply in progress
               expected_in = in_slave_ff;
               awaiting_in = 1'b1;
               rx_cnt_in   = RX_ADDR;
               rx_crc_in   = CRC_INIT;
               hdr_good_in = 1'b1;
               data_in     = 16'h0000;
               crc_lo_in   = 8'h00;
               elapsed_in  = '0;
            end
            OP_RX_BYTE: begin
               if (awaiting_ff) begin
                  if (rx_cnt_ff < RX_CRC_L) begin
                     rx_crc_in = rx_crc_next;
                     rx_cnt_in = rx_cnt_ff + 3'd1;
                     if ((rx_cnt_ff == RX_ADDR) && (in_rx_ff != expected_ff)) begin
                        hdr_good_in = 1'b0;
                     end
                     if ((rx_cnt_ff == RX_FUNC) && (in_rx_ff != FUNC_READ_HOLD)) begin
                        hdr_good_in = 1'b0;
                     end
                     if ((rx_cnt_ff == RX_COUNT) && (in_rx_ff != BYTE_COUNT_ONE)) begin
                        hdr_good_in = 1'b0;
                     end
                     if (rx_cnt_ff == RX_DATA_H) begin
                        data_in = {in_rx_ff, data_ff[7:0]};
                     end
                     if (rx_cnt_ff == RX_DATA_L) begin
                        data_in = {data_ff[15:8], in_rx_ff};
                     end
                  end else if (rx_cnt_ff == RX_CRC_L) begin
                     crc_lo_in = in_rx_ff;
                     rx_cnt_in = RX_CRC_H;
                  end else begin
                     awaiting_in = 1'b0;
                     rx_cnt_in   = RX_DONE;
                  end
               end
            end
            OP_TICK: begin
               if (awaiting_ff) begin
                  elapsed_in = elapsed_sat;
                  if (elapsed_sat >= timeout_ff) begin
                     awaiting_in = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         timeout_ff  <= TIMEOUT_RESET;
         expected_ff <= 8'h00;
         awaiting_ff <= 1'b0;
         rx_cnt_ff   <= RX_ADDR;
         rx_crc_ff   <= CRC_INIT;
         hdr_good_ff <= 1'b1;
         data_ff     <= 16'h0000;
         crc_lo_ff   <= 8'h00;
         elapsed_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         timeout_ff  <= timeout_in;
         expected_ff <= expected_in;
         awaiting_ff <= awaiting_in;
         rx_cnt_ff   <= rx_cnt_in;
         rx_crc_ff   <= rx_crc_in;
         hdr_good_ff <= hdr_good_in;
         data_ff     <= data_in;
         crc_lo_ff   <= crc_lo_in;
         elapsed_ff  <= elapsed_in;
      end
      if (req_fire) begin
         in_op_ff    <= req_tuser;
         in_slave_ff <= req_tdata[7:0];
         in_reg_ff   <= req_tdata[23:8];
         in_rx_ff    <= req_tdata[31:24];
      end
   end

   mbrr_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (ld),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTH
   // while a reply is being gathered the count never sits at the done mark
   a_await_cnt: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> (rx_cnt_ff != RX_DONE))
      else $error("reply tracker awaiting with completed byte count");

   // a held request word keeps its opcode
   a_hold_op: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !go) |=> (in_valid_ff && $stable(in_op_ff)))
      else $error("stalled request word lost or changed");

   // the closing frame byte is a transmit word with clear status and value
   a_last_tx: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> ((rsp_tuser == KIND_TX) && (rsp_tdata[25:8] == 18'd0)))
      else $error("frame end marked on a non-transmit word");
`endif

endmodule
